FILE: rtl/clamped_gradient_with_minmax_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the clamped gradient unit
// Each macro expands to one labeled concurrent assertion, clocked on clock and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef CLAMPED_GRADIENT_WITH_MINMAX_UNIT_ASSERT_SVH
`define CLAMPED_GRADIENT_WITH_MINMAX_UNIT_ASSERT_SVH

// same-cycle implication
`define CGM_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cgm: same-cycle check failed");

// next-cycle implication
`define CGM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cgm: next-cycle check failed");

`endif

FILE: rtl/cgm_pkg.sv
// ----------------------------------------------------------------------------
// cgm_pkg
// Shared types, register codes and helpers of the clamped gradient unit.
// ----------------------------------------------------------------------------
package cgm_pkg;

   localparam int PIX_W            = 8;
   localparam int WIDTH_REG_W      = 11;
   localparam int HEIGHT_REG_W     = 13;
   localparam int CSR_DATA_W       = 13;
   localparam int CSR_ADDR_W       = 1;
   localparam int FRAME_WIDTH_RST  = 1024;
   localparam int FRAME_HEIGHT_RST = 1024;
   localparam int MIN_FRAME_DIM    = 2;
   localparam int NUM_CELLS        = 2;
   localparam int MAX_RESULTS      = 3;
   localparam int CNT_W            = 2;
   localparam int IDX_W            = 2;
   localparam int RSP_DATA_W       = 48;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
   localparam logic [PIX_W-1:0] PIX_MIN = 8'h00;

   typedef logic [PIX_W-1:0] pixel_type;

   // one line store entry: two rows up and one row up
   typedef struct packed {
      pixel_type older;
      pixel_type prev;
   } entry_type;

   // one window column: row above and current row
   typedef struct packed {
      pixel_type upper;
      pixel_type lower;
   } cell_type;

   typedef struct packed {
      pixel_type gx;
      pixel_type gy;
   } result_type;

   typedef struct packed {
      pixel_type x_min;
      pixel_type x_max;
      pixel_type y_min;
      pixel_type y_max;
   } extremes_type;

   // position of a pixel inside the frame
   typedef struct packed {
      logic has_top;
      logic top_first;
      logic last_row;
      logic col_first;
      logic col_second;
      logic col_last;
   } pos_flags_type;

   // later minus earlier, clamped at zero
   function automatic pixel_type pos_diff(input pixel_type earlier, input pixel_type later);
      pos_diff = (later > earlier) ? pixel_type'(later - earlier) : PIX_MIN;
   endfunction

endpackage

FILE: rtl/clamped_gradient_with_minmax_unit.sv
// ----------------------------------------------------------------------------
// clamped_gradient_with_minmax_unit
// Central-difference image gradient with negative values clamped to zero and
// per-frame minimum and maximum of both gradients.
//
//   channel | dir | fields
//   --------+-----+--------------------------------------------------------
//   req_    | in  | tdata: pixel
//   rsp_    | out | tdata: grad_x..grad_y_max, tlast: frame_done, tuser: run_end
//   csr_    | in  | 0: frame_width, 1: frame_height
//
// One pixel is accepted per cycle while the output keeps up; its first result
// passes the first stage and the result bundle registers to the output port.
// The last row yields two results per pixel (one for its first pixel) and the
// final pixel three, so there the one-word-per-cycle output port sets the rate.
// A pixel of the first row yields no result. Reset is synchronous; the line
// memory is not cleared. Output stalls hold the result and back up the input.
// ----------------------------------------------------------------------------
module clamped_gradient_with_minmax_unit
   import cgm_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel in
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // [7:0] pixel
   // result out
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // grad_x, grad_y, grad_x_min,
                                              // grad_x_max, grad_y_min, grad_y_max
   output logic                  rsp_tlast,   // frame_done
   output logic                  rsp_tuser,   // run_end
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
   localparam int LAST_COL_RST =
      ((FRAME_WIDTH_RST < MAX_WIDTH) ? FRAME_WIDTH_RST : MAX_WIDTH) - 1;
   localparam int LAST_ROW_RST =
      ((FRAME_HEIGHT_RST < MAX_HEIGHT) ? FRAME_HEIGHT_RST : MAX_HEIGHT) - 1;

   // configuration and position
   logic [CW-1:0] last_col_ff, last_col_in;
   logic [RW-1:0] last_row_ff, last_row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [31:0]   width_clamp, height_clamp;
   logic          cfg_restart;
   logic          accept;
   pos_flags_type pos;

   // line store
   entry_type ent_rd, ent_wr;

   // window cells and first stage
   cell_type      cell_d    [NUM_CELLS];
   cell_type      cell_q    [NUM_CELLS];
   pixel_type     cell_vert [NUM_CELLS];
   pixel_type     lower2_ff;
   pixel_type     older_ff;
   pos_flags_type flags_ff;
   logic          s1_valid_ff;
   logic          s1_go;

   // result bundle
   result_type       res_in [MAX_RESULTS];
   result_type       res_ff [MAX_RESULTS];
   logic [CNT_W-1:0] n_in, cnt_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             fdone_ff;
   logic             b_valid, b_last, b_free, fire, load, done;
   result_type       cur;
   extremes_type     ext, ext_out;
   pixel_type        left1, right1, left2;

   // clamp written sizes into range
   always_comb begin
      width_clamp  = 32'(csr_wdata[WIDTH_REG_W-1:0]);
      height_clamp = 32'(csr_wdata[HEIGHT_REG_W-1:0]);
      if (width_clamp < 32'(MIN_FRAME_DIM))   width_clamp = 32'(MIN_FRAME_DIM);
      if (width_clamp > 32'(MAX_WIDTH))       width_clamp = 32'(MAX_WIDTH);
      if (height_clamp < 32'(MIN_FRAME_DIM))  height_clamp = 32'(MIN_FRAME_DIM);
      if (height_clamp > 32'(MAX_HEIGHT))     height_clamp = 32'(MAX_HEIGHT);
      last_col_in = CW'(width_clamp - 32'd1);
      last_row_in = RW'(height_clamp - 32'd1);
   end

   assign cfg_restart = csr_we &&
                        ((csr_addr == CSR_FRAME_WIDTH) || (csr_addr == CSR_FRAME_HEIGHT));

   // hold the frame size in its clamped form
   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= CW'(LAST_COL_RST);
         last_row_ff <= RW'(LAST_ROW_RST);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FRAME_WIDTH:  last_col_ff <= last_col_in;
            CSR_FRAME_HEIGHT: last_row_ff <= last_row_in;
            default: ;
         endcase
      end
   end

   // locate the incoming pixel
   always_comb begin
      pos.col_first  = (col_ff == '0);
      pos.col_second = (col_ff == CW'(1));
      pos.col_last   = (col_ff == last_col_ff);
      pos.has_top    = (row_ff != '0);
      pos.top_first  = (row_ff == RW'(1));
      pos.last_row   = (row_ff == last_row_ff);
      col_in = pos.col_last ? '0 : col_ff + CW'(1);
      row_in = row_ff;
      if (pos.col_last) begin
         row_in = pos.last_row ? '0 : row_ff + RW'(1);
      end
   end

   assign req_tready = !s1_valid_ff || s1_go;
   assign accept     = req_tvalid && req_tready;

   // advance column and row, restart on configuration
   always_ff @(posedge clock) begin
      if (reset || cfg_restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // store this column, fetch the next column's entry
   assign ent_wr.older = ent_rd.prev;
   assign ent_wr.prev  = req_tdata;

   cgm_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_store (
      .clock   (clock),
      .en      (accept),
      .wr_addr (col_ff),
      .wr_data (ent_wr),
      .rd_addr (col_in),
      .rd_data (ent_rd)
   );

   // window: chain of column cells
   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign cell_d[k] = '{upper: ent_rd.prev, lower: req_tdata};
      end else begin : g_link
         assign cell_d[k] = cell_q[k-1];
      end
      cgm_cell u_cell (
         .clock (clock),
         .shift (accept),
         .d     (cell_d[k]),
         .q     (cell_q[k]),
         .vert  (cell_vert[k])
      );
   end

   // first stage side registers
   always_ff @(posedge clock) begin
      if (accept) begin
         lower2_ff <= cell_q[NUM_CELLS-1].lower;
         older_ff  <= ent_rd.older;
         flags_ff  <= pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // form the results of one pixel; ent_rd now holds the right neighbor above
   always_comb begin
      left1  = flags_ff.col_first  ? cell_q[0].upper : cell_q[1].upper;
      right1 = flags_ff.col_last   ? cell_q[0].upper : ent_rd.prev;
      left2  = flags_ff.col_second ? cell_q[1].lower : lower2_ff;
      res_in[0].gx = pos_diff(left1, right1);
      res_in[0].gy = flags_ff.top_first ? cell_vert[0]
                                        : pos_diff(older_ff, cell_q[0].lower);
      res_in[1].gx = pos_diff(left2, cell_q[0].lower);
      res_in[1].gy = cell_vert[1];
      res_in[2].gx = pos_diff(cell_q[1].lower, cell_q[0].lower);
      res_in[2].gy = cell_vert[0];
      n_in = CNT_W'(flags_ff.has_top)
           + CNT_W'(flags_ff.last_row && !flags_ff.col_first)
           + CNT_W'(flags_ff.last_row && flags_ff.col_last);
   end

   // result bundle handshake
   assign b_valid = (cnt_ff != '0);
   assign b_last  = (idx_ff == IDX_W'(cnt_ff - CNT_W'(1)));
   assign fire    = b_valid && rsp_tready;
   assign b_free  = !b_valid || (rsp_tready && b_last);
   assign s1_go   = s1_valid_ff && ((n_in == '0) || b_free);
   assign load    = s1_go && (n_in != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (load) begin
         cnt_ff <= n_in;
         idx_ff <= '0;
      end else if (fire) begin
         if (b_last) begin
            cnt_ff <= '0;
         end else begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff   <= res_in;
         fdone_ff <= flags_ff.last_row && flags_ff.col_last;
      end
   end

   assign cur  = res_ff[idx_ff];
   assign done = fdone_ff && b_last;

   cgm_stats u_stats (
      .clock (clock),
      .reset (reset),
      .clear (cfg_restart),
      .take  (fire),
      .last  (done),
      .cur   (cur),
      .ext   (ext)
   );

   // drive the result word
   assign ext_out    = done ? ext : '0;
   assign rsp_tvalid = b_valid;
   assign rsp_tdata  = {ext_out.y_max, ext_out.y_min, ext_out.x_max, ext_out.x_min,
                        cur.gy, cur.gx};
   assign rsp_tlast  = done;
   assign rsp_tuser  = b_last;

endmodule

FILE: rtl/cgm_line_store.sv
// ----------------------------------------------------------------------------
// cgm_line_store
// Line memory holding the two rows above the current one, one entry per
// column; one write and one registered read per accepted pixel.
// ----------------------------------------------------------------------------
module cgm_line_store
   import cgm_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_ff;

   // write the current column, fetch the next one
   always_ff @(posedge clock) begin
      if (en) begin
         mem[wr_addr] <= wr_data;
         rd_ff        <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

FILE: rtl/cgm_cell.sv
// ----------------------------------------------------------------------------
// cgm_cell
// One window column: holds the pixel above and the current pixel, passes them
// to the next cell on shift and gives their clamped vertical difference.
// ----------------------------------------------------------------------------
module cgm_cell
   import cgm_pkg::*;
(
   input  logic      clock,
   input  logic      shift,
   input  cell_type  d,
   output cell_type  q,
   output pixel_type vert
);

   cell_type q_ff;

   // advance the window on each accepted word
   always_ff @(posedge clock) begin
      if (shift) begin
         q_ff <= d;
      end
   end

   assign q    = q_ff;
   assign vert = pos_diff(q_ff.upper, q_ff.lower);

endmodule

FILE: rtl/cgm_stats.sv
// ----------------------------------------------------------------------------
// cgm_stats
// Running minimum and maximum of both gradients over the frame; the outputs
// already include the result currently on the output port.
// ----------------------------------------------------------------------------
module cgm_stats
   import cgm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         clear,
   input  logic         take,
   input  logic         last,
   input  result_type   cur,
   output extremes_type ext
);

   pixel_type x_min_ff, x_max_ff, y_min_ff, y_max_ff;

   // fold the current result into the running values
   always_comb begin
      ext.x_min = (cur.gx < x_min_ff) ? cur.gx : x_min_ff;
      ext.x_max = (cur.gx > x_max_ff) ? cur.gx : x_max_ff;
      ext.y_min = (cur.gy < y_min_ff) ? cur.gy : y_min_ff;
      ext.y_max = (cur.gy > y_max_ff) ? cur.gy : y_max_ff;
   end

   // update on each delivered word, restart after the frame's final word
   always_ff @(posedge clock) begin
      if (reset || clear || (take && last)) begin
         x_min_ff <= PIX_MAX;
         x_max_ff <= PIX_MIN;
         y_min_ff <= PIX_MAX;
         y_max_ff <= PIX_MIN;
      end else if (take) begin
         x_min_ff <= ext.x_min;
         x_max_ff <= ext.x_max;
         y_min_ff <= ext.y_min;
         y_max_ff <= ext.y_max;
      end
   end

endmodule

FILE: rtl/cgm_checker.sv
// ----------------------------------------------------------------------------
// cgm_checker
// Port-level checks on the result channel of the clamped gradient unit.
// ----------------------------------------------------------------------------
`include "clamped_gradient_with_minmax_unit_assert.svh"

module cgm_checker
   import cgm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast,
   input logic                  rsp_tuser
);

   logic x_in_bounds, y_in_bounds;

   // each gradient against its reported minimum and maximum
   assign x_in_bounds = (rsp_tdata[23:16] <= rsp_tdata[7:0]) &&
                        (rsp_tdata[7:0] <= rsp_tdata[31:24]);
   assign y_in_bounds = (rsp_tdata[39:32] <= rsp_tdata[15:8]) &&
                        (rsp_tdata[15:8] <= rsp_tdata[47:40]);

   // the frame's final word is always the last word of its pixel
   `CGM_ASSERT_SAME(a_done_ends_run, rsp_tvalid && rsp_tlast, rsp_tuser)

   // extremes read zero away from the frame's end
   `CGM_ASSERT_SAME(a_ext_zero, rsp_tvalid && !rsp_tlast, rsp_tdata[47:16] == 32'd0)

   // the final word's own gradients lie within the reported extremes
   `CGM_ASSERT_SAME(a_ext_bound, rsp_tvalid && rsp_tlast, x_in_bounds && y_in_bounds)

   // a stalled word stays put
   `CGM_ASSERT_NEXT(a_stall_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

endmodule

bind clamped_gradient_with_minmax_unit cgm_checker u_cgm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
